// ===== hw/rtl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list package
// Sizes, command and status codes, and the decoded command record shared by
// the list control and the command check.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int DEPTH     = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CMD_W     = 3;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int OUT_CNT_W = 5;
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READOUT   = 3'd6;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [ST_W-1:0]  status;
    logic [PTR_W-1:0] idx;
  } chk_t;

endpackage

// ===== hw/rtl/pol_store.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list element store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module pol_store (
  input  logic                              clk,
  input  logic                              we,
  input  logic [pol_pkg::PTR_W-1:0]         waddr,
  input  logic [pol_pkg::VAL_W-1:0]         wdata,
  input  logic [pol_pkg::PTR_W-1:0]         raddr,
  output logic [pol_pkg::VAL_W-1:0]         rdata
);

  logic [pol_pkg::VAL_W-1:0] mem [pol_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pol_check.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list command check
// Validates a command against the current count and yields the operation,
// the status and the 0-based target index of the operation.
// ----------------------------------------------------------------------------
module pol_check (
  input  logic [pol_pkg::CMD_W-1:0] cmd,
  input  logic [pol_pkg::POS_W-1:0] position,
  input  logic [pol_pkg::CNT_W-1:0] count,
  output pol_pkg::chk_t             chk
);

  logic [pol_pkg::CMP_W-1:0] cnt_x;
  logic [pol_pkg::CMP_W-1:0] pos_x;
  logic [pol_pkg::CMP_W-1:0] idx_x;
  logic                      full;
  logic                      empty;

  assign cnt_x = pol_pkg::CMP_W'(count);
  assign pos_x = pol_pkg::CMP_W'(position);
  assign full  = (cnt_x == pol_pkg::CMP_W'(pol_pkg::DEPTH));
  assign empty = (count == '0);

  always_comb begin
    chk.op     = pol_pkg::OP_NONE;
    chk.status = pol_pkg::ST_OK;
    idx_x      = '0;
    unique case (cmd)
      pol_pkg::CMD_INS_FRONT, pol_pkg::CMD_INS_BACK, pol_pkg::CMD_INS_AT: begin
        if (full) begin
          chk.status = pol_pkg::ST_FULL;
        end else if (cmd == pol_pkg::CMD_INS_FRONT) begin
          chk.op = pol_pkg::OP_INS;
        end else if (cmd == pol_pkg::CMD_INS_BACK) begin
          chk.op = pol_pkg::OP_INS;
          idx_x  = cnt_x;
        end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
          chk.status = pol_pkg::ST_BADPOS;
        end else begin
          chk.op = pol_pkg::OP_INS;
          idx_x  = pos_x - 1'b1;
        end
      end
      pol_pkg::CMD_DEL_FRONT, pol_pkg::CMD_DEL_BACK, pol_pkg::CMD_DEL_AT: begin
        if (empty) begin
          chk.status = pol_pkg::ST_EMPTY;
        end else if (cmd == pol_pkg::CMD_DEL_FRONT) begin
          chk.op = pol_pkg::OP_DEL;
        end else if (cmd == pol_pkg::CMD_DEL_BACK) begin
          chk.op = pol_pkg::OP_DEL;
          idx_x  = cnt_x - 1'b1;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          chk.status = pol_pkg::ST_BADPOS;
        end else begin
          chk.op = pol_pkg::OP_DEL;
          idx_x  = pos_x - 1'b1;
        end
      end
      pol_pkg::CMD_READOUT: begin
        if (empty) begin
          chk.status = pol_pkg::ST_EMPTY;
        end else begin
          chk.op = pol_pkg::OP_READ;
        end
      end
      default: begin
        chk.op = pol_pkg::OP_NONE;
      end
    endcase
    chk.idx = idx_x[pol_pkg::PTR_W-1:0];
  end

endmodule

// ===== hw/rtl/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list
// Ordered list of up to DEPTH signed words with insert, delete and read-out
// commands, held in a memory and shifted one entry at a time.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every result word
// appears for exactly one cycle with out_valid high and cannot be held off.
// A failed command, an empty read-out or an unused code gives its result
// in the cycle after it is taken and leaves busy low. An insert at 0-based
// index i walks the list from the tail down to i, and a delete walks it from
// i up to the tail: each moved word costs one memory read and one write on
// the single store port pair. A read-out alternates between issuing a read
// and emitting the registered memory read data, and busy stays high until
// the last word. The last result of a command appears in the same cycle in
// which busy falls.
module positional_ordered_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [pol_pkg::CMD_W-1:0]         in_command,
  input  logic signed [pol_pkg::VAL_W-1:0]  in_value,
  input  logic [pol_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic [pol_pkg::ST_W-1:0]          out_status,
  output logic [pol_pkg::OUT_CNT_W-1:0]     out_count,
  output logic signed [pol_pkg::VAL_W-1:0]  out_element,
  output logic                              out_last
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_WR   = 3'd2;
  localparam logic [2:0] S_DEL_RD   = 3'd3;
  localparam logic [2:0] S_DEL_WR   = 3'd4;
  localparam logic [2:0] S_RD_ISSUE = 3'd5;
  localparam logic [2:0] S_RD_EMIT  = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [pol_pkg::PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [pol_pkg::PTR_W-1:0]   idx_r, idx_nxt;
  logic [pol_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic [pol_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic [pol_pkg::ST_W-1:0]    ostatus_r, ostatus_nxt;
  logic [pol_pkg::VAL_W-1:0]   oelem_r, oelem_nxt;
  logic                        olast_r, olast_nxt;

  logic                        we;
  logic [pol_pkg::PTR_W-1:0]   waddr;
  logic [pol_pkg::VAL_W-1:0]   wdata;
  logic [pol_pkg::PTR_W-1:0]   raddr;
  logic [pol_pkg::VAL_W-1:0]   rdata;
  logic [pol_pkg::CNT_W-1:0]   ptr_inc;
  pol_pkg::chk_t               chk;

  pol_check u_check (
    .cmd      (in_command),
    .position (in_position),
    .count    (count_r),
    .chk      (chk)
  );

  pol_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy    = (state_r != S_IDLE);
  assign ptr_inc = pol_pkg::CNT_W'(ptr_r) + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    ovalid_nxt  = 1'b0;
    ostatus_nxt = ostatus_r;
    oelem_nxt   = oelem_r;
    olast_nxt   = olast_r;
    we          = 1'b0;
    waddr       = ptr_r;
    wdata       = rdata;
    raddr       = ptr_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt = chk.idx;
          val_nxt = in_value;
          unique case (chk.op)
            pol_pkg::OP_INS: begin
              ptr_nxt   = count_r[pol_pkg::PTR_W-1:0];
              state_nxt = S_INS_RD;
            end
            pol_pkg::OP_DEL: begin
              ptr_nxt   = chk.idx;
              state_nxt = S_DEL_RD;
            end
            pol_pkg::OP_READ: begin
              ptr_nxt   = '0;
              state_nxt = S_RD_ISSUE;
            end
            default: begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = chk.status;
              oelem_nxt   = '0;
              olast_nxt   = 1'b1;
            end
          endcase
        end
      end
      // Insert walks from the tail down to the target index, moving one
      // word up per read/write pair, then drops the new word in.
      S_INS_RD: begin
        if (ptr_r == idx_r) begin
          we          = 1'b1;
          wdata       = val_r;
          count_nxt   = count_r + 1'b1;
          ovalid_nxt  = 1'b1;
          ostatus_nxt = pol_pkg::ST_OK;
          oelem_nxt   = '0;
          olast_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          raddr     = ptr_r - 1'b1;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we        = 1'b1;
        ptr_nxt   = ptr_r - 1'b1;
        state_nxt = S_INS_RD;
      end
      // Delete walks from the target index up, pulling each next word down.
      S_DEL_RD: begin
        if (ptr_inc >= count_r) begin
          count_nxt   = count_r - 1'b1;
          ovalid_nxt  = 1'b1;
          ostatus_nxt = pol_pkg::ST_OK;
          oelem_nxt   = '0;
          olast_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          raddr     = ptr_r + 1'b1;
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        we        = 1'b1;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_DEL_RD;
      end
      S_RD_ISSUE: begin
        state_nxt = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        ovalid_nxt  = 1'b1;
        ostatus_nxt = pol_pkg::ST_OK;
        oelem_nxt   = rdata;
        olast_nxt   = (ptr_inc == count_r);
        if (ptr_inc == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_RD_ISSUE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    ptr_r     <= ptr_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    ostatus_r <= ostatus_nxt;
    oelem_r   <= oelem_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid   = ovalid_r;
  assign out_status  = ostatus_r;
  assign out_count   = pol_pkg::OUT_CNT_W'(count_r);
  assign out_element = oelem_r;
  assign out_last    = olast_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional ordered list testbench
// Drives insert, delete and read-out commands through the start/busy port.
// It starts with a table of directed commands and then sends random command
// streams that sweep the list between empty and full. A local list model or
// a row's typed result predicts each result word, checked as it is strobed out.
// ----------------------------------------------------------------------------
module tb_top;
  import pol_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 377;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic [OUT_CNT_W-1:0]    count;
    logic signed [VAL_W-1:0] element;
    logic                    last;
  } list_word_t;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [VAL_W-1:0]     val;
    logic [POS_W-1:0]     pos;
    int                   reps;
    bit                   typed;
    logic [ST_W-1:0]      st;
    logic [OUT_CNT_W-1:0] cnt;
  } cmd_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic [CMD_W-1:0]        in_command = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    busy;
  logic                    out_valid;
  logic [ST_W-1:0]         out_status;
  logic [OUT_CNT_W-1:0]    out_count;
  logic signed [VAL_W-1:0] out_element;
  logic                    out_last;

  logic signed [VAL_W-1:0] list_mem [DEPTH];
  int                      list_len = 0;
  list_word_t              expected_words [$];
  cmd_row_t                directed_rows [$];
  int                      error_count = 0;

  always #1 clk = ~clk;

  positional_ordered_list dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_command  (in_command),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_count   (out_count),
    .out_element (out_element),
    .out_last    (out_last)
  );

  // Applies one command to the local list and, when asked, queues the words
  // the block should return for it.
  task automatic apply_list_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos, input bit record);
    logic [ST_W-1:0] st;
    int              idx;
    int              i;
    list_word_t      w;
    st = ST_OK;
    idx = 0;
    if (cmd == CMD_READOUT) begin
      if (list_len == 0) begin
        w = '{ST_EMPTY, '0, '0, 1'b1};
        if (record) expected_words.push_back(w);
      end else begin
        for (i = 0; i < list_len; i++) begin
          w = '{ST_OK, 5'(list_len), list_mem[i], (i + 1 == list_len)};
          if (record) expected_words.push_back(w);
        end
      end
    end else begin
      case (cmd)
        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
          if (list_len >= DEPTH) begin
            st = ST_FULL;
          end else if (cmd == CMD_INS_AT && (pos == 0 || int'(pos) > list_len + 1)) begin
            st = ST_BADPOS;
          end else begin
            if (cmd == CMD_INS_BACK) idx = list_len;
            else if (cmd == CMD_INS_AT) idx = int'(pos) - 1;
            for (i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
            list_mem[idx] = val;
            list_len++;
          end
        end
        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
          if (list_len == 0) begin
            st = ST_EMPTY;
          end else if (cmd == CMD_DEL_AT && (pos == 0 || int'(pos) > list_len)) begin
            st = ST_BADPOS;
          end else begin
            if (cmd == CMD_DEL_BACK) idx = list_len - 1;
            else if (cmd == CMD_DEL_AT) idx = int'(pos) - 1;
            for (i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
          end
        end
        default: begin
        end
      endcase
      w = '{st, 5'(list_len), '0, 1'b1};
      if (record) expected_words.push_back(w);
    end
  endtask

  // Holds the command on the port until the block takes it. A start that is
  // already high from the previous word is left alone.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    in_command  <= cmd;
    in_value    <= val;
    in_position <= pos;
    if (!start) start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  task automatic idle_gap(input bit quiet);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 25);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic cmd_row_t mk_row(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                                      logic [POS_W-1:0] pos, int reps, bit typed,
                                      logic [ST_W-1:0] st, logic [OUT_CNT_W-1:0] cnt);
    cmd_row_t r;
    r = '{cmd, val, pos, reps, typed, st, cnt};
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin : result_check
    list_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word status=%0d count=%0d element=%0d last=%0b",
                 $time, out_status, out_count, out_element, out_last);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, out_count);
          error_count++;
        end
        if (out_element !== want.element) begin
          $display("%0t: element expected %0d actual %0d", $time, want.element, out_element);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    #600000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    cmd_row_t         row;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    list_word_t       w;
    int               k;
    int               n;
    int               r;
    bit               filling;
    bit               quiet;

    // Empty list, bad positions, the extremes of value and position, and a
    // full list. Rows with typed results are plain enough to check by eye.
    directed_rows.push_back(mk_row(CMD_READOUT,   '0, 5'd0, 1, 1, ST_EMPTY, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_FRONT, '0, 5'd0, 1, 1, ST_EMPTY, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_BACK,  '0, 5'd0, 1, 1, ST_EMPTY, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd0, 1, 1, ST_EMPTY, 5'd0));
    directed_rows.push_back(mk_row(CMD_INS_AT, 32'h1234_5678, 5'd0, 1, 1, ST_BADPOS, 5'd0));
    directed_rows.push_back(mk_row(CMD_INS_AT, 32'h1234_5678, 5'd2, 1, 1, ST_BADPOS, 5'd0));
    directed_rows.push_back(mk_row(CMD_INS_FRONT, 32'h7FFF_FFFF, 5'd0, 1, 1, ST_OK, 5'd1));
    directed_rows.push_back(mk_row(CMD_INS_BACK,  32'h8000_0000, 5'd0, 1, 1, ST_OK, 5'd2));
    directed_rows.push_back(mk_row(CMD_INS_AT,    32'hFFFF_FFFF, 5'd2, 1, 1, ST_OK, 5'd3));
    directed_rows.push_back(mk_row(CMD_INS_AT,    32'h0000_0000, 5'd4, 1, 1, ST_OK, 5'd4));
    directed_rows.push_back(mk_row(CMD_INS_AT,    32'h5555_5555, 5'd1, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_READOUT,   32'hFFFF_FFFF, 5'd31, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd0, 1, 1, ST_BADPOS, 5'd5));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd6, 1, 1, ST_BADPOS, 5'd5));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd5, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd1, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_FRONT, '0, 5'd0, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_BACK,  '0, 5'd0, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_UNUSED,    32'hFFFF_FFFF, 5'd31, 1, 1, ST_OK, 5'd1));
    directed_rows.push_back(mk_row(CMD_READOUT,   '0, 5'd0, 1, 0, ST_OK, 5'd0));
    // Fill the list to the top with random words.
    directed_rows.push_back(mk_row(CMD_INS_BACK,  '0, 5'd0, DEPTH - 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_INS_AT,    32'hAAAA_AAAA, 5'd31, 1, 1, ST_FULL, 5'd16));
    directed_rows.push_back(mk_row(CMD_INS_FRONT, 32'hAAAA_AAAA, 5'd0, 1, 1, ST_FULL, 5'd16));
    directed_rows.push_back(mk_row(CMD_INS_BACK,  32'hAAAA_AAAA, 5'd0, 1, 1, ST_FULL, 5'd16));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd31, 1, 1, ST_BADPOS, 5'd16));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd17, 1, 1, ST_BADPOS, 5'd16));
    directed_rows.push_back(mk_row(CMD_READOUT,   '0, 5'd0, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_DEL_AT,    '0, 5'd16, 1, 0, ST_OK, 5'd0));
    directed_rows.push_back(mk_row(CMD_INS_AT,    32'h0F0F_0F0F, 5'd16, 1, 0, ST_OK, 5'd0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (k = 0; k < row.reps; k++) begin
        val = (row.reps > 1) ? pick_value() : row.val;
        send_cmd(row.cmd, val, row.pos);
        apply_list_cmd(row.cmd, val, row.pos, !row.typed);
        if (row.typed) begin
          w = '{row.st, row.cnt, '0, 1'b1};
          expected_words.push_back(w);
        end
        idle_gap(1'b0);
      end
    end

    // Random streams that drift between filling and draining the list, with
    // stretches of back-to-back words.
    filling = 1'b1;
    quiet = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (list_len == DEPTH && filling && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (list_len == 0 && !filling) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = !filling;

      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_UNUSED;
      else if (r < 11) cmd = CMD_READOUT;
      else if (r < (filling ? 80 : 35)) cmd = CMD_INS_FRONT + 3'($urandom_range(0, 2));
      else cmd = CMD_DEL_FRONT + 3'($urandom_range(0, 2));

      val = pick_value();
      if ($urandom_range(0, 99) < 15) pos = 5'($urandom_range(0, 31));
      else if (cmd == CMD_INS_AT) pos = 5'($urandom_range(1, list_len + 1));
      else if (cmd == CMD_DEL_AT) pos = 5'($urandom_range(1, (list_len > 0) ? list_len : 1));
      else pos = 5'($urandom_range(0, 31));

      send_cmd(cmd, val, pos);
      apply_list_cmd(cmd, val, pos, 1'b1);
      idle_gap(quiet);
    end

    if (start) start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== positional_ordered_list.f =====
hw/rtl/pol_pkg.sv
hw/rtl/pol_store.sv
hw/rtl/pol_check.sv
hw/rtl/positional_ordered_list.sv
tb/tb_top.sv
